[sv/mel_to_cepstrum_dct_unit_assert.svh]
// Assertion macros for the mel-to-cepstrum DCT unit.
// Included by the top level; no other dependencies.
`ifndef MEL_TO_CEPSTRUM_DCT_UNIT_ASSERT_SVH
`define MEL_TO_CEPSTRUM_DCT_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define MCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define MCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[sv/mcd_pkg.sv]
// Shared widths, constants and types of the mel-to-cepstrum DCT unit.
// No dependencies; used by every module of the block.
package mcd_pkg;

  localparam int MEL_W       = 16;   // mel energy, unsigned
  localparam int COEF_W      = 16;   // DCT coefficient, signed Q1.15
  localparam int PROD_W      = 32;   // mel times coefficient
  localparam int ACC_W       = 38;   // per-row accumulator
  localparam int VAL_W       = 25;   // output value, 4 fractional bits
  localparam int IDX_W       = 4;    // output coefficient index
  localparam int RND_SHIFT   = 11;   // Q15 down to Q4
  localparam int SUM_W       = ACC_W + 1;
  localparam int SH_W        = SUM_W - RND_SHIFT;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD     = OUT_TDATA_W - VAL_W - IDX_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic             last;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } out_item_t;

endpackage

[sv/mel_to_cepstrum_dct_unit.sv]
// Mel filterbank to cepstrum DCT-II unit: top level.
// Usage: send one frame as NUM_BANDS requests on the in_ channel, one unsigned
// 16-bit mel energy each, in ascending bin order; the bin count alone marks
// the frame end. After the last bin the out_ channel returns NUM_COEFFS
// requests, coefficient 0 first, out_tlast set on the final one.
// The last bin passes through the request queue, the lane registers and the result bank
// to the output register; then one coefficient per cycle while out_tready stays high.
// Throughput is one mel value per cycle, set by the thirteen parallel
// multiply-accumulate lanes behind a four-entry request queue.
// Each frame's sums move to a result bank at frame end, so the next frame
// accumulates while the previous one drains. A frame that ends before the
// bank is free holds the lanes; the queue then fills and in_tready drops.
// A stalled receiver keeps the current output request stable.
// cfg_data written through the cfg_ channel sets clear_first_coeff, which
// forces coefficient 0 to zero; write it only while the unit is idle.
// Reset clears the accumulators and bin count and sets clear_first_coeff.
`include "mel_to_cepstrum_dct_unit_assert.svh"

module mel_to_cepstrum_dct_unit #(
  parameter int NUM_BANDS  = 64,
  parameter int NUM_COEFFS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] mel_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mcd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [3:0] coeff_index, [28:4] coeff_value
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);

  localparam int BIN_W = $clog2(NUM_BANDS);
  localparam int QW    = 1 + BIN_W + mcd_pkg::MEL_W;

  logic                          clear_first_r;
  logic                          q_push, q_pop, q_full, q_empty;
  logic [BIN_W-1:0]              f_bin, b_bin;
  logic                          f_last, b_last;
  logic [mcd_pkg::MEL_W-1:0]     f_mel, b_mel;
  logic [QW-1:0]                 q_rdata;
  logic                          bank_load, bank_busy;
  mcd_pkg::acc_t                 sums [NUM_COEFFS];
  mcd_pkg::out_item_t            out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_first_r <= 1'b1;
    end else if (cfg_valid) begin
      clear_first_r <= cfg_data;
    end
  end

  mcd_front #(.NUM_BANDS(NUM_BANDS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mel   (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bin    (f_bin),
    .q_last   (f_last),
    .q_mel    (f_mel)
  );

  mcd_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_last, f_bin, f_mel}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_last, b_bin, b_mel} = q_rdata;

  mcd_mac #(.NUM_BANDS(NUM_BANDS), .NUM_COEFFS(NUM_COEFFS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_bin     (b_bin),
    .q_last    (b_last),
    .q_mel     (b_mel),
    .q_pop     (q_pop),
    .bank_busy (bank_busy),
    .bank_load (bank_load),
    .sums      (sums)
  );

  mcd_emit #(.NUM_COEFFS(NUM_COEFFS)) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .bank_load   (bank_load),
    .sums        (sums),
    .bank_busy   (bank_busy),
    .clear_first (clear_first_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_item    (out_item)
  );

  assign out_tdata = {{mcd_pkg::OUT_PAD{1'b0}}, out_item.value, out_item.index};
  assign out_tlast = out_item.last;

  // The front end must never push into a full queue.
  `MCD_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, q_full, !q_push, "push into full queue")
  // A finished frame may only be handed over into a free result bank.
  `MCD_ASSERT_IMP(a_bank_free_on_load, clk, rst_n, bank_load, !bank_busy, "bank overwritten")
  // A handed-over frame occupies the bank until it has been sent.
  `MCD_ASSERT_NXT(a_bank_held_after_load, clk, rst_n, bank_load, bank_busy, "bank not held")

endmodule

[sv/mcd_queue.sv]
// Short FIFO between the front end and the multiply-accumulate back end.
// Depends on mcd_pkg for its depth.
module mcd_queue #(
  parameter int W = 23
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]                mem_r [mcd_pkg::Q_DEPTH];
  logic [mcd_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mcd_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mcd_pkg::Q_PTR_W:0]   count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full    = (count_r == (mcd_pkg::Q_PTR_W + 1)'(mcd_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[sv/mcd_front.sv]
// Front end: takes mel values, numbers them by bin and tags the frame end.
// Depends on mcd_pkg; feeds mcd_queue.
module mcd_front #(
  parameter int NUM_BANDS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mcd_pkg::MEL_W-1:0]    in_mel,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [$clog2(NUM_BANDS)-1:0] q_bin,
  output logic                         q_last,
  output logic [mcd_pkg::MEL_W-1:0]    q_mel
);

  localparam int BIN_W = $clog2(NUM_BANDS);

  logic [BIN_W-1:0] bin_r, bin_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_bin    = bin_r;
  assign q_last   = (bin_r == BIN_W'(NUM_BANDS - 1));
  assign q_mel    = in_mel;

  always_comb begin
    bin_nxt = bin_r;
    if (q_push) begin
      bin_nxt = q_last ? '0 : bin_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else begin
      bin_r <= bin_nxt;
    end
  end

endmodule

[sv/mcd_mac.sv]
// Back end: coefficient ROM, one multiply-accumulate lane per cepstral row.
// Depends on mcd_pkg; hands each finished frame to mcd_emit.
module mcd_mac #(
  parameter int NUM_BANDS  = 64,
  parameter int NUM_COEFFS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [$clog2(NUM_BANDS)-1:0] q_bin,
  input  logic                         q_last,
  input  logic [mcd_pkg::MEL_W-1:0]    q_mel,
  output logic                         q_pop,
  input  logic                         bank_busy,
  output logic                         bank_load,
  output mcd_pkg::acc_t                sums [NUM_COEFFS]
);

  localparam int ROM_BITS = NUM_COEFFS * NUM_BANDS * mcd_pkg::COEF_W;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    v     = v_in;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > v) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v   = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // One Taylor term divisor, sine series when odd is set, cosine otherwise.
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k,
                                             input logic odd);
    logic [63:0] r;
    r = t;
    if (odd) begin
      case (k)
        1: r = t / 6;
        2: r = t / 20;
        3: r = t / 42;
        4: r = t / 72;
        5: r = t / 110;
        6: r = t / 156;
        7: r = t / 210;
        8: r = t / 272;
        9: r = t / 342;
        10: r = t / 420;
        11: r = t / 506;
        12: r = t / 600;
        default: r = t;
      endcase
    end else begin
      case (k)
        1: r = t / 2;
        2: r = t / 12;
        3: r = t / 30;
        4: r = t / 56;
        5: r = t / 90;
        6: r = t / 132;
        7: r = t / 182;
        8: r = t / 240;
        9: r = t / 306;
        10: r = t / 380;
        11: r = t / 462;
        12: r = t / 552;
        default: r = t;
      endcase
    end
    return r;
  endfunction

  // Sine or cosine of a Q30 angle below pi/2, truncating at each term.
  function automatic logic [63:0] trig_q30(input logic [63:0] x, input logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = odd ? x : Q30_ONE;
    sum  = signed'(term);
    for (int k = 1; k <= 12; k++) begin
      term = taylor_div((term * x2) >> 30, k, odd);
      if ((k % 2) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    return unsigned'(sum);
  endfunction

  function automatic logic [mcd_pkg::COEF_W-1:0] rom_entry(input int n, input int k);
    logic [63:0] alpha;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] c;
    logic        neg;
    alpha = (n == 0) ? isqrt64((64'd1 << 60) / NUM_BANDS)
                     : isqrt64((64'd2 << 60) / NUM_BANDS);
    p     = (64'(2 * k + 1) * 64'(n)) % (4 * NUM_BANDS);
    q     = p / NUM_BANDS;
    r     = p % NUM_BANDS;
    x     = (HALF_PI_Q30 * r) / NUM_BANDS;
    mag   = trig_q30(x, q[0]);
    neg   = (q == 64'd1) || (q == 64'd2);
    c     = (alpha * mag + (64'd1 << 44)) >> 45;
    if (c > 64'd32767) c = 64'd32767;
    return neg ? mcd_pkg::COEF_W'(~c + 64'd1) : mcd_pkg::COEF_W'(c);
  endfunction

  function automatic logic [ROM_BITS-1:0] build_rom();
    logic [ROM_BITS-1:0] rom;
    rom = '0;
    for (int n = 0; n < NUM_COEFFS; n++) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        rom[(n * NUM_BANDS + k) * mcd_pkg::COEF_W +: mcd_pkg::COEF_W] = rom_entry(n, k);
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] DCT_ROM = build_rom();

  logic                          go;
  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic [mcd_pkg::MEL_W-1:0]     s1_mel_r;
  mcd_pkg::coef_t                s1_coef_r [NUM_COEFFS];
  logic                          s2_valid_r;
  logic                          s2_last_r;
  mcd_pkg::prod_t                s2_prod_r [NUM_COEFFS];
  mcd_pkg::acc_t                 acc_r     [NUM_COEFFS];

  // The whole lane pipeline holds while a frame end waits for a free bank.
  assign go        = !(s2_valid_r && s2_last_r && bank_busy);
  assign q_pop     = go && !q_empty;
  assign bank_load = go && s2_valid_r && s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (go) begin
      s1_valid_r <= q_pop;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (q_pop) begin
        s1_last_r <= q_last;
        s1_mel_r  <= q_mel;
      end
      s2_last_r <= s1_last_r;
    end
  end

  for (genvar n = 0; n < NUM_COEFFS; n++) begin : g_lane
    mcd_pkg::prod_t prod_nxt;

    assign prod_nxt = mcd_pkg::PROD_W'($signed({1'b0, s1_mel_r}))
                      * mcd_pkg::PROD_W'(s1_coef_r[n]);
    assign sums[n]  = acc_r[n] + mcd_pkg::ACC_W'(s2_prod_r[n]);

    always_ff @(posedge clk) begin
      if (go) begin
        if (q_pop) begin
          s1_coef_r[n] <= DCT_ROM[(n * NUM_BANDS + int'(q_bin)) * mcd_pkg::COEF_W
                                  +: mcd_pkg::COEF_W];
        end
        s2_prod_r[n] <= prod_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[n] <= '0;
      end else if (go && s2_valid_r) begin
        acc_r[n] <= s2_last_r ? '0 : sums[n];
      end
    end
  end

endmodule

[sv/mcd_emit.sv]
// Result stage: holds one finished frame and sends its coefficients in order,
// rounded to four fractional bits. Depends on mcd_pkg; fed by mcd_mac.
module mcd_emit #(
  parameter int NUM_COEFFS = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bank_load,
  input  mcd_pkg::acc_t       sums [NUM_COEFFS],
  output logic                bank_busy,
  input  logic                clear_first,
  output logic                out_valid,
  input  logic                out_ready,
  output mcd_pkg::out_item_t  out_item
);

  localparam int CNT_W = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
  localparam logic signed [mcd_pkg::SUM_W-1:0] RND_BIAS =
    mcd_pkg::SUM_W'(1 << (mcd_pkg::RND_SHIFT - 1));
  localparam logic signed [mcd_pkg::SH_W-1:0] VAL_MAX =
    mcd_pkg::SH_W'((1 << (mcd_pkg::VAL_W - 1)) - 1);
  localparam logic signed [mcd_pkg::SH_W-1:0] VAL_MIN = -VAL_MAX - mcd_pkg::SH_W'(1);

  mcd_pkg::acc_t                     bank_r [NUM_COEFFS];
  logic                              busy_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic                              out_valid_r;
  mcd_pkg::out_item_t                out_item_r;
  logic                              adv;
  logic                              cnt_last;
  logic signed [mcd_pkg::SUM_W-1:0]  biased;
  logic signed [mcd_pkg::SH_W-1:0]   shifted;
  logic signed [mcd_pkg::SH_W-1:0]   clamped;
  mcd_pkg::out_item_t                item_nxt;

  assign bank_busy = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign cnt_last  = (cnt_r == CNT_W'(NUM_COEFFS - 1));

  // Round half up: add half an output step, then arithmetic shift.
  always_comb begin
    biased  = mcd_pkg::SUM_W'(bank_r[cnt_r]) + RND_BIAS;
    shifted = mcd_pkg::SH_W'(biased >>> mcd_pkg::RND_SHIFT);
    if (shifted > VAL_MAX) begin
      clamped = VAL_MAX;
    end else if (shifted < VAL_MIN) begin
      clamped = VAL_MIN;
    end else begin
      clamped = shifted;
    end
    item_nxt.index = mcd_pkg::IDX_W'(cnt_r);
    item_nxt.last  = cnt_last;
    item_nxt.value = mcd_pkg::VAL_W'(clamped);
    if (cnt_r == '0 && clear_first) begin
      item_nxt.value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (bank_load) begin
        busy_r <= 1'b1;
      end else if (adv && cnt_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        cnt_r       <= cnt_last ? '0 : cnt_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= item_nxt;
    end
    if (bank_load) begin
      bank_r <= sums;
    end
  end

endmodule
